>>> rtl/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes of the sorted timer queue
// Command and status codes, the per-cell operation code and the control
// group that the sequencer broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CONN_W       = 16;
  localparam int TIME_W       = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // Broadcast control group from the sequencer to the cell row.
  typedef struct packed {
    cell_op_t            op;
    logic [TIME_W-1:0]   key;
    logic [CONN_W-1:0]   id;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/stq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted timer row
// Holds one expiry time and connection id. On insert it keeps its entry,
// loads the new one or takes its left neighbor's; on remove it takes its
// right neighbor's when it sits at or after the removal point.
// ----------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [IDX_W-1:0]  pos,
  input  wire logic              valid,
  input  wire logic              left_le,
  input  wire logic [TIME_W-1:0] left_expiry,
  input  wire logic [CONN_W-1:0] left_conn,
  input  wire logic [TIME_W-1:0] right_expiry,
  input  wire logic [CONN_W-1:0] right_conn,
  output logic [TIME_W-1:0]      expiry,
  output logic [CONN_W-1:0]      conn,
  output logic                   le,
  output logic                   match
);

  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  logic [CONN_W-1:0] conn_r, conn_nxt;

  // Entry is due or sorts at or before the key; ids are compared for lookup.
  assign le    = valid && (expiry_r <= ctl.key);
  assign match = valid && (conn_r == ctl.id);

  // Pick the next content of the slot.
  always_comb begin
    expiry_nxt = expiry_r;
    conn_nxt   = conn_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (!le) begin
          if (left_le) begin
            expiry_nxt = ctl.key;
            conn_nxt   = ctl.id;
          end else begin
            expiry_nxt = left_expiry;
            conn_nxt   = left_conn;
          end
        end
      end
      CELL_REMOVE: begin
        if (pos <= IDX_W'(IDX)) begin
          expiry_nxt = right_expiry;
          conn_nxt   = right_conn;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    expiry_r <= expiry_nxt;
    conn_r   <= conn_nxt;
  end

  assign expiry = expiry_r;
  assign conn   = conn_r;

endmodule
`default_nettype wire

>>> rtl/sorted_timer_queue.sv
`default_nettype none
// Add ends in the lookup state; a found delete or adjust goes on to remove, adjust then to insert.
// Tick: from the lookup state into the pop loop, then one expired item per cycle.
// Throughput: one command at a time; busy drops in the cycle of the last result.
// On each insert or remove the row of cells shifts all entries from that point on at once.
// Reset clears the entry count and the sequencer; slot contents stay as is.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// sorted_timer_queue: timer list kept sorted by expiry in a row of cells
// A sequencer looks up ids across the row, then broadcasts insert or remove
// steps that every cell carries out against its neighbors at once.
// ----------------------------------------------------------------------------
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [CONN_W-1:0]   in_conn_id,
  input  wire logic [TIME_W-1:0]   in_expire_time,
  input  wire logic [TIME_W-1:0]   in_now_time,
  output logic                     out_valid,
  output logic [CONN_W-1:0]        out_conn_id,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_REMOVE = 5'b00100,
    S_INSERT = 5'b01000,
    S_TICK   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  cmd_t              cmd_r;
  logic [CONN_W-1:0] id_r;
  logic [TIME_W-1:0] exp_r;
  logic [TIME_W-1:0] now_r;

  logic                out_valid_r, out_valid_nxt;
  logic [CONN_W-1:0]   out_conn_id_r, out_conn_id_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  cell_ctl_t         ctl;
  logic [IDX_W-1:0]  pos_sel;
  logic [IDX_W-1:0]  hit_pos;
  logic              hit;

  logic [TIME_W-1:0] cell_expiry [CAPACITY];
  logic [CONN_W-1:0] cell_conn   [CAPACITY];
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_match;

  // The row of cells, each wired to its left and right neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              l_le;
    logic [TIME_W-1:0] l_exp, r_exp;
    logic [CONN_W-1:0] l_conn, r_conn;

    if (i == 0) begin : g_head
      assign l_le   = 1'b1;
      assign l_exp  = '0;
      assign l_conn = '0;
    end else begin : g_body
      assign l_le   = cell_le[i-1];
      assign l_exp  = cell_expiry[i-1];
      assign l_conn = cell_conn[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_exp  = '0;
      assign r_conn = '0;
    end else begin : g_next
      assign r_exp  = cell_expiry[i+1];
      assign r_conn = cell_conn[i+1];
    end

    stq_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .pos          (pos_sel),
      .valid        (count_r > CNT_W'(i)),
      .left_le      (l_le),
      .left_expiry  (l_exp),
      .left_conn    (l_conn),
      .right_expiry (r_exp),
      .right_conn   (r_conn),
      .expiry       (cell_expiry[i]),
      .conn         (cell_conn[i]),
      .le           (cell_le[i]),
      .match        (cell_match[i])
    );
  end

  // Encode the single matching slot; ids in the row are unique.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pos = hit_pos | (cell_match[i] ? IDX_W'(i) : '0);
    end
  end
  assign hit = |cell_match;

  // Sequencer: lookup, then remove and insert steps, or a tick pop loop.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    ctl.op          = CELL_HOLD;
    ctl.key         = (cmd_r == CMD_TICK) ? now_r : exp_r;
    ctl.id          = id_r;
    pos_sel         = pos_r;
    out_valid_nxt   = 1'b0;
    out_conn_id_nxt = id_r;
    out_status_nxt  = ST_OK;
    out_last_nxt    = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        case (cmd_r)
          CMD_ADD: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (hit) begin
              out_status_nxt = ST_DUPLICATE;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              out_status_nxt = ST_FULL;
            end else begin
              ctl.op    = CELL_INSERT;
              count_nxt = count_r + 1'b1;
            end
          end
          CMD_ADJUST, CMD_DELETE: begin
            if (hit) begin
              pos_nxt   = hit_pos;
              state_nxt = S_REMOVE;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_TICK;
          end
        endcase
      end
      S_REMOVE: begin
        ctl.op    = CELL_REMOVE;
        count_nxt = count_r - 1'b1;
        if (cmd_r == CMD_ADJUST) begin
          state_nxt = S_INSERT;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INSERT: begin
        ctl.op        = CELL_INSERT;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_TICK: begin
        pos_sel       = '0;
        out_valid_nxt = 1'b1;
        if (cell_le[0]) begin
          // Pop the head; it is the last one unless the next slot is due too.
          ctl.op          = CELL_REMOVE;
          count_nxt       = count_r - 1'b1;
          out_conn_id_nxt = cell_conn[0];
          out_status_nxt  = ST_EXPIRED;
          out_last_nxt    = !cell_le[1];
          if (!cell_le[1]) begin
            state_nxt = S_IDLE;
          end
        end else begin
          out_conn_id_nxt = '0;
          out_status_nxt  = ST_NONE;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= cmd_t'(in_cmd);
      id_r  <= in_conn_id;
      exp_r <= in_expire_time;
      now_r <= in_now_time;
    end
    pos_r         <= pos_nxt;
    out_conn_id_r <= out_conn_id_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_conn_id = out_conn_id_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

  // The entry count never passes the row length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An id is held in at most one slot.
  a_unique_id: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOKUP |-> $onehot0(cell_match))
    else $error("connection id held in more than one slot");

  // Each tick pop removes exactly one entry.
  a_tick_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && cell_le[0]) |=> count_r == $past(count_r) - 1'b1)
    else $error("tick pop did not shrink the queue by one");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule
`default_nettype wire

>>> tb/timer_queue_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timer_queue_checker: result predictor and scoreboard for the timer queue
// Watches the command and result channels of sorted_timer_queue. It keeps
// its own sorted copy of the timer list and computes the results of every
// accepted item. It then compares each strobed result, field by field, with
// the oldest result still due.
// ----------------------------------------------------------------------------
module timer_queue_checker
  import stq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [CONN_W-1:0]   in_conn_id,
  input  wire logic [TIME_W-1:0]   in_expire_time,
  input  wire logic [TIME_W-1:0]   in_now_time,
  input  wire logic                out_valid,
  input  wire logic [CONN_W-1:0]   out_conn_id,
  input  wire logic [STATUS_W-1:0] out_status,
  input  wire logic                out_last,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic [CONN_W-1:0] conn;
    status_t           status;
    logic              is_last;
  } timer_result_t;

  // Shadow copy of the timer list, earliest expiry first.
  logic [TIME_W-1:0] slot_expiry [CAPACITY];
  logic [CONN_W-1:0] slot_conn   [CAPACITY];
  int                slot_count;

  timer_result_t due_results [$];
  timer_result_t want;
  int            errors;

  initial begin
    fail_count = 0;
    pending    = 0;
    errors     = 0;
    slot_count = 0;
  end

  // Position of an id in the list, or -1 when it is absent.
  function automatic int find_slot(input logic [CONN_W-1:0] id);
    for (int i = 0; i < slot_count; i++) begin
      if (slot_conn[i] == id) return i;
    end
    return -1;
  endfunction

  // Close the gap left by the entry at pos.
  task automatic drop_slot(input int pos);
    for (int i = pos; i + 1 < slot_count; i++) begin
      slot_expiry[i] = slot_expiry[i+1];
      slot_conn[i]   = slot_conn[i+1];
    end
    slot_count--;
  endtask

  // New entries go behind every entry with an equal or earlier expiry.
  task automatic place_sorted(input logic [CONN_W-1:0] id, input logic [TIME_W-1:0] expiry);
    int pos;
    pos = 0;
    while (pos < slot_count && slot_expiry[pos] <= expiry) pos++;
    for (int i = slot_count; i > pos; i--) begin
      slot_expiry[i] = slot_expiry[i-1];
      slot_conn[i]   = slot_conn[i-1];
    end
    slot_expiry[pos] = expiry;
    slot_conn[pos]   = id;
    slot_count++;
  endtask

  // Update the shadow list for one item and queue the results it causes.
  task automatic predict_timer_cmd(input cmd_t cmd, input logic [CONN_W-1:0] id,
                                   input logic [TIME_W-1:0] expiry,
                                   input logic [TIME_W-1:0] now);
    int   pos;
    int   popped;
    logic is_final;
    pos = find_slot(id);
    case (cmd)
      CMD_ADD: begin
        // A duplicate id is reported even when the list is full.
        if (pos >= 0) begin
          due_results.push_back('{conn: id, status: ST_DUPLICATE, is_last: 1'b1});
        end else if (slot_count >= CAPACITY) begin
          due_results.push_back('{conn: id, status: ST_FULL, is_last: 1'b1});
        end else begin
          place_sorted(id, expiry);
          due_results.push_back('{conn: id, status: ST_OK, is_last: 1'b1});
        end
      end
      CMD_ADJUST: begin
        if (pos < 0) begin
          due_results.push_back('{conn: id, status: ST_NOT_FOUND, is_last: 1'b1});
        end else begin
          drop_slot(pos);
          place_sorted(id, expiry);
          due_results.push_back('{conn: id, status: ST_OK, is_last: 1'b1});
        end
      end
      CMD_DELETE: begin
        if (pos < 0) begin
          due_results.push_back('{conn: id, status: ST_NOT_FOUND, is_last: 1'b1});
        end else begin
          drop_slot(pos);
          due_results.push_back('{conn: id, status: ST_OK, is_last: 1'b1});
        end
      end
      default: begin
        // Pop from the head while it has expired; the final pop carries last.
        popped = 0;
        while (slot_count > 0 && slot_expiry[0] <= now) begin
          is_final = !(slot_count > 1 && slot_expiry[1] <= now);
          due_results.push_back('{conn: slot_conn[0], status: ST_EXPIRED, is_last: is_final});
          drop_slot(0);
          popped++;
        end
        if (popped == 0) begin
          due_results.push_back('{conn: '0, status: ST_NONE, is_last: 1'b1});
        end
      end
    endcase
  endtask

  // Predict on every accepted item, then check any strobed result.
  always @(posedge clk) begin
    if (!rst_n) begin
      slot_count = 0;
      due_results.delete();
    end else begin
      if (start && !busy) begin
        predict_timer_cmd(cmd_t'(in_cmd), in_conn_id, in_expire_time, in_now_time);
      end
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual conn %h status %0d last %b",
                   $time, out_conn_id, out_status, out_last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_conn_id !== want.conn) begin
            $display("%0t: conn id mismatch: expected %h, actual %h",
                     $time, want.conn, out_conn_id);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            errors++;
          end
          if (out_last !== want.is_last) begin
            $display("%0t: last flag mismatch: expected %b, actual %b",
                     $time, want.is_last, out_last);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= due_results.size();
  end

endmodule
`default_nettype wire

>>> tb/sorted_timer_queue_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue_tb: command stimulus and verdict for the timer queue
// Sends a directed set of commands that cover the corner cases, then random
// segments of mixed commands and list fills, with sender gaps in bursts.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int TOTAL_ITEMS = 450;
  localparam int QUIET_FROM  = TOTAL_ITEMS - 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd;
  logic [CONN_W-1:0]   in_conn_id;
  logic [TIME_W-1:0]   in_expire_time;
  logic [TIME_W-1:0]   in_now_time;
  logic                out_valid;
  logic [CONN_W-1:0]   out_conn_id;
  logic [STATUS_W-1:0] out_status;
  logic                out_last;
  int                  fail_count;
  int                  pending;

  int                  issued;
  logic [TIME_W-1:0]   clock_now;
  bit                  idling;

  sorted_timer_queue DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_conn_id     (in_conn_id),
    .in_expire_time (in_expire_time),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_conn_id    (out_conn_id),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  timer_queue_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_conn_id     (in_conn_id),
    .in_expire_time (in_expire_time),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_conn_id    (out_conn_id),
    .out_status     (out_status),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Free-running clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Present one item and hold it until the block accepts it.
  task automatic issue_cmd(input cmd_t cmd, input logic [CONN_W-1:0] id,
                           input logic [TIME_W-1:0] expiry,
                           input logic [TIME_W-1:0] now);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_conn_id     <= id;
    in_expire_time <= expiry;
    in_now_time    <= now;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    issued++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted result has been seen.
  task automatic wait_all_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Idle bursts only in idling segments and never near the end of the run.
  task automatic maybe_idle();
    if (idling && issued < QUIET_FROM && $urandom_range(0, 2) == 0) begin
      pause_sender($urandom_range(1, 17));
    end
  endtask

  // Expiries mostly land just ahead of the running time so ticks pop some.
  function automatic logic [TIME_W-1:0] pick_expiry();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return clock_now + $urandom_range(0, 60);
  endfunction

  // Fill the list past capacity, poke it while full, then flush it.
  task automatic fill_segment();
    logic [CONN_W-1:0] base;
    base = CONN_W'($urandom_range(0, 65535));
    for (int k = 0; k < 64; k++) begin
      maybe_idle();
      issue_cmd(CMD_ADD, CONN_W'(base + k), pick_expiry(), $urandom);
    end
    issue_cmd(CMD_ADD, base, pick_expiry(), $urandom);
    issue_cmd(CMD_ADD, CONN_W'(base + 100), pick_expiry(), $urandom);
    issue_cmd(CMD_ADJUST, CONN_W'(base + 3), pick_expiry(), $urandom);
    issue_cmd(CMD_DELETE, CONN_W'(base + 5), $urandom, $urandom);
    issue_cmd(CMD_ADD, CONN_W'(base + 100), pick_expiry(), $urandom);
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'hFFFF_FFFF);
  endtask

  // Mixed commands on a small pool of ids so most of them hit live entries.
  task automatic mixed_segment(input int count);
    logic [CONN_W-1:0] base;
    logic [CONN_W-1:0] id;
    int                pick;
    base = CONN_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0) clock_now = $urandom;
    for (int k = 0; k < count; k++) begin
      maybe_idle();
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 11) == 0) ? CONN_W'($urandom_range(0, 65535))
                                          : CONN_W'(base + $urandom_range(0, 39));
      if (pick < 35) begin
        issue_cmd(CMD_ADD, id, pick_expiry(), $urandom);
      end else if (pick < 55) begin
        issue_cmd(CMD_ADJUST, id, pick_expiry(), $urandom);
      end else if (pick < 70) begin
        issue_cmd(CMD_DELETE, id, $urandom, $urandom);
      end else begin
        clock_now = clock_now + $urandom_range(0, 15);
        issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom,
                  ($urandom_range(0, 19) == 0) ? $urandom : clock_now);
      end
    end
  endtask

  // Stimulus: reset, directed corner cases, random segments, drain, verdict.
  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_cmd         <= CMD_ADD;
    in_conn_id     <= '0;
    in_expire_time <= '0;
    in_now_time    <= '0;
    issued         = 0;
    clock_now      = 32'd1000;
    idling         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: nothing expires, and lookups miss.
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'h0);
    issue_cmd(CMD_DELETE, 16'h0005, $urandom, $urandom);
    issue_cmd(CMD_ADJUST, 16'h0005, $urandom, $urandom);
    // Extreme ids and expiries, then a duplicate add.
    issue_cmd(CMD_ADD, 16'h0000, 32'h0, $urandom);
    issue_cmd(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, $urandom);
    issue_cmd(CMD_ADD, 16'h0000, 32'd7, $urandom);
    // Equal expiries keep insertion order; adjust earlier and later.
    issue_cmd(CMD_ADD, 16'h1234, 32'd100, $urandom);
    issue_cmd(CMD_ADD, 16'h4321, 32'd100, $urandom);
    issue_cmd(CMD_ADD, 16'h5555, 32'd100, $urandom);
    issue_cmd(CMD_ADJUST, 16'h1234, 32'd100, $urandom);
    issue_cmd(CMD_ADJUST, 16'h4321, 32'd50, $urandom);
    issue_cmd(CMD_ADJUST, 16'h0000, 32'd200, $urandom);
    issue_cmd(CMD_DELETE, 16'h5555, $urandom, $urandom);
    issue_cmd(CMD_DELETE, 16'h5555, $urandom, $urandom);
    wait_all_results();
    // Ticks just below, at and above the expiries present.
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'd99);
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'd99);
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'd100);
    issue_cmd(CMD_ADD, 16'hAAAA, 32'hFFFF_FFFF, $urandom);
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'hFFFF_FFFE);
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'hFFFF_FFFF);
    issue_cmd(CMD_TICK, CONN_W'($urandom), $urandom, 32'hFFFF_FFFF);

    // One full fill first, then settle before the random mix.
    idling = 1'b1;
    fill_segment();
    wait_all_results();
    while (issued < TOTAL_ITEMS) begin
      idling = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 7) == 0) begin
        fill_segment();
      end else begin
        mixed_segment($urandom_range(20, 50));
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue.sv
tb/timer_queue_checker.sv
tb/sorted_timer_queue_tb.sv
